// File: design/pcb_clearance_rule_check_core_defines.svh
// ----------------------------------------------------------------------------
// Clearance rule check assertion macros
// Shared concurrent assertion forms for the checker. The macros expect clk and
// rst_n to exist in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PCB_CLEARANCE_RULE_CHECK_CORE_DEFINES_SVH
`define PCB_CLEARANCE_RULE_CHECK_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clearance check assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clearance check assertion failed");

`endif

// File: design/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// Clearance rule check package
// Widths, codes and payload types shared by the clearance check block.
// ----------------------------------------------------------------------------
package pcrc_pkg;

    // Coordinate and arithmetic widths.
    localparam int COORD_BITS  = 24;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam int HALF_LO     = (SUM_BITS + 1) / 2;
    localparam int HALF_HI     = SUM_BITS - HALF_LO;
    localparam int NUM_BITS    = 2 * SUM_BITS;
    localparam int DIST_BITS   = 25;
    localparam int KD_BITS     = SUM_BITS + DIST_BITS;
    localparam int REM_BITS    = NUM_BITS + 2;

    // Pipeline depths.
    localparam int LANE_LAT    = 5;
    localparam int PIPE_LAT    = LANE_LAT + DIST_BITS;
    localparam int NUM_LANES   = 4;

    // Field widths and rule constants.
    localparam int ACTION_BITS = 3;
    localparam int WIDTH_BITS  = 16;
    localparam int CLEAR_BITS  = 20;
    localparam int SEV_BITS    = 2;
    localparam int PAD_MARGIN       = 2000;
    localparam int PAD_OVERLAP_DIST = 1000;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_WIDTH       = 3'd0,
        ACT_TRACK_TRACK = 3'd1,
        ACT_TRACK_PAD   = 3'd2,
        ACT_PAD_PAD     = 3'd3,
        ACT_PAD_OUTLINE = 3'd4
    } action_t;

    typedef enum logic [SEV_BITS-1:0] {
        SEV_NONE  = 2'd0,
        SEV_WARN  = 2'd1,
        SEV_ERROR = 2'd2
    } severity_t;

    typedef enum logic [2:0] {
        REG_WIDTH_FLOOR    = 3'd0,
        REG_CLEAR_FLOOR    = 3'd1,
        REG_OUTLINE_ENABLE = 3'd2,
        REG_BOARD_MIN_X    = 3'd3,
        REG_BOARD_MIN_Y    = 3'd4,
        REG_BOARD_MAX_X    = 3'd5,
        REG_BOARD_MAX_Y    = 3'd6
    } reg_index_t;

    // Which distance a segment lane reports.
    typedef enum logic [1:0] {
        SEL_START = 2'd0,
        SEL_END   = 2'd1,
        SEL_PERP  = 2'd2
    } near_sel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0]       action;
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
        logic [WIDTH_BITS-1:0]        track_width;
    } req_t;

    typedef struct packed {
        logic [SEV_BITS-1:0]  severity;
        logic [DIST_BITS-1:0] measured_distance;
    } rsp_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]        width_floor;
        logic [CLEAR_BITS-1:0]        clear_floor;
        logic                         outline_enable;
        logic signed [COORD_BITS-1:0] board_min_x;
        logic signed [COORD_BITS-1:0] board_min_y;
        logic signed [COORD_BITS-1:0] board_max_x;
        logic signed [COORD_BITS-1:0] board_max_y;
    } cfg_t;

    // Item data that bypasses the distance lanes.
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [WIDTH_BITS-1:0]  track_width;
        logic                   outside;
    } side_t;

endpackage

// File: design/pcrc_if.sv
// ----------------------------------------------------------------------------
// Clearance rule check channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface pcrc_req_if;
    import pcrc_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pcrc_rsp_if;
    import pcrc_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/pcrc_cfg.sv
// ----------------------------------------------------------------------------
// Clearance rule check register file
// APB-style register block holding the rule thresholds and the board box.
// ----------------------------------------------------------------------------
module pcrc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcrc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [pcrc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [pcrc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output pcrc_pkg::cfg_t                    cfg
);
    import pcrc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_WIDTH_FLOOR:    cfg_next.width_floor    = pwdata[WIDTH_BITS-1:0];
                REG_CLEAR_FLOOR:    cfg_next.clear_floor    = pwdata[CLEAR_BITS-1:0];
                REG_OUTLINE_ENABLE: cfg_next.outline_enable = pwdata[0];
                REG_BOARD_MIN_X:    cfg_next.board_min_x    = pwdata[COORD_BITS-1:0];
                REG_BOARD_MIN_Y:    cfg_next.board_min_y    = pwdata[COORD_BITS-1:0];
                REG_BOARD_MAX_X:    cfg_next.board_max_x    = pwdata[COORD_BITS-1:0];
                REG_BOARD_MAX_Y:    cfg_next.board_max_y    = pwdata[COORD_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (index)
            REG_WIDTH_FLOOR:    prdata = CFG_DATA_BITS'(cfg_reg.width_floor);
            REG_CLEAR_FLOOR:    prdata = CFG_DATA_BITS'(cfg_reg.clear_floor);
            REG_OUTLINE_ENABLE: prdata = CFG_DATA_BITS'(cfg_reg.outline_enable);
            REG_BOARD_MIN_X:    prdata = CFG_DATA_BITS'(unsigned'(cfg_reg.board_min_x));
            REG_BOARD_MIN_Y:    prdata = CFG_DATA_BITS'(unsigned'(cfg_reg.board_min_y));
            REG_BOARD_MAX_X:    prdata = CFG_DATA_BITS'(unsigned'(cfg_reg.board_max_x));
            REG_BOARD_MAX_Y:    prdata = CFG_DATA_BITS'(unsigned'(cfg_reg.board_max_y));
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/pcrc_seg_lane.sv
// ----------------------------------------------------------------------------
// Clearance rule check segment lane
// Five-stage pipeline that turns a segment and a point into a numerator and a
// denominator whose quotient is the squared point-to-segment distance.
// ----------------------------------------------------------------------------
module pcrc_seg_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  pcrc_pkg::point_t               seg_a,
    input  pcrc_pkg::point_t               seg_b,
    input  pcrc_pkg::point_t               pt,
    output logic                           out_valid,
    output logic [pcrc_pkg::NUM_BITS-1:0]  num,
    output logic [pcrc_pkg::SUM_BITS-1:0]  den
);
    import pcrc_pkg::*;

    logic [LANE_LAT-1:0] valid_reg;

    // Stage 1: coordinate differences.
    logic signed [DIFF_BITS-1:0] abx_reg, aby_reg, apx_reg, apy_reg, bpx_reg, bpy_reg;
    // Stage 2: products.
    logic signed [PROD_BITS-1:0] abxx_reg, abyy_reg, dotx_reg, doty_reg;
    logic signed [PROD_BITS-1:0] crs1_reg, crs2_reg, apxx_reg, apyy_reg, bpxx_reg, bpyy_reg;
    // Stage 3: sums.
    logic signed [SUM_BITS-1:0]  ab2_reg, dot_reg, cross_reg, pa2_reg, pb2_reg;
    // Stage 4: selection and partial products of the squared cross term.
    near_sel_t                   sel_reg;
    logic [SUM_BITS-1:0]         ab2u_reg, pa2u_reg, pb2u_reg;
    logic [2*HALF_HI-1:0]        hh_reg;
    logic [HALF_HI+HALF_LO-1:0]  hl_reg;
    logic [2*HALF_LO-1:0]        ll_reg;
    // Stage 5: outputs.
    logic [NUM_BITS-1:0]         num_reg;
    logic [SUM_BITS-1:0]         den_reg;

    near_sel_t                   sel_next;
    logic [SUM_BITS-1:0]         mag;
    logic [HALF_HI-1:0]          mag_hi;
    logic [HALF_LO-1:0]          mag_lo;
    logic [NUM_BITS-1:0]         num_next;
    logic [SUM_BITS-1:0]         den_next;

    // Pick the nearest feature: an end point or the perpendicular foot.
    always_comb
    begin
        if ((ab2_reg == '0) || dot_reg[SUM_BITS-1])
        begin
            sel_next = SEL_START;
        end
        else if (dot_reg > ab2_reg)
        begin
            sel_next = SEL_END;
        end
        else
        begin
            sel_next = SEL_PERP;
        end
        mag    = cross_reg[SUM_BITS-1] ? SUM_BITS'(-cross_reg) : SUM_BITS'(cross_reg);
        mag_hi = mag[SUM_BITS-1:HALF_LO];
        mag_lo = mag[HALF_LO-1:0];
    end

    // Recombine the squared cross term or pass the end point distance.
    always_comb
    begin
        case (sel_reg)
            SEL_START:
            begin
                num_next = NUM_BITS'(pa2u_reg);
                den_next = SUM_BITS'(1);
            end
            SEL_END:
            begin
                num_next = NUM_BITS'(pb2u_reg);
                den_next = SUM_BITS'(1);
            end
            SEL_PERP:
            begin
                num_next = (NUM_BITS'(hh_reg) << (2 * HALF_LO))
                         + (NUM_BITS'(hl_reg) << (HALF_LO + 1))
                         + NUM_BITS'(ll_reg);
                den_next = ab2u_reg;
            end
            default:
            begin
                num_next = '0;
                den_next = SUM_BITS'(1);
            end
        endcase
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LANE_LAT-2:0], in_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx_reg   <= DIFF_BITS'(seg_b.x) - DIFF_BITS'(seg_a.x);
            aby_reg   <= DIFF_BITS'(seg_b.y) - DIFF_BITS'(seg_a.y);
            apx_reg   <= DIFF_BITS'(pt.x) - DIFF_BITS'(seg_a.x);
            apy_reg   <= DIFF_BITS'(pt.y) - DIFF_BITS'(seg_a.y);
            bpx_reg   <= DIFF_BITS'(pt.x) - DIFF_BITS'(seg_b.x);
            bpy_reg   <= DIFF_BITS'(pt.y) - DIFF_BITS'(seg_b.y);

            abxx_reg  <= abx_reg * abx_reg;
            abyy_reg  <= aby_reg * aby_reg;
            dotx_reg  <= apx_reg * abx_reg;
            doty_reg  <= apy_reg * aby_reg;
            crs1_reg  <= apx_reg * aby_reg;
            crs2_reg  <= apy_reg * abx_reg;
            apxx_reg  <= apx_reg * apx_reg;
            apyy_reg  <= apy_reg * apy_reg;
            bpxx_reg  <= bpx_reg * bpx_reg;
            bpyy_reg  <= bpy_reg * bpy_reg;

            ab2_reg   <= SUM_BITS'(abxx_reg) + SUM_BITS'(abyy_reg);
            dot_reg   <= SUM_BITS'(dotx_reg) + SUM_BITS'(doty_reg);
            cross_reg <= SUM_BITS'(crs1_reg) - SUM_BITS'(crs2_reg);
            pa2_reg   <= SUM_BITS'(apxx_reg) + SUM_BITS'(apyy_reg);
            pb2_reg   <= SUM_BITS'(bpxx_reg) + SUM_BITS'(bpyy_reg);

            sel_reg   <= sel_next;
            ab2u_reg  <= SUM_BITS'(ab2_reg);
            pa2u_reg  <= SUM_BITS'(pa2_reg);
            pb2u_reg  <= SUM_BITS'(pb2_reg);
            hh_reg    <= mag_hi * mag_hi;
            hl_reg    <= mag_hi * mag_lo;
            ll_reg    <= mag_lo * mag_lo;

            num_reg   <= num_next;
            den_reg   <= den_next;
        end
    end

    assign out_valid = valid_reg[LANE_LAT-1];
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

// File: design/pcrc_root.sv
// ----------------------------------------------------------------------------
// Clearance rule check root pipeline
// One result bit per stage: finds the largest k with k*k*den <= num by
// restoring digit recurrence, keeping k*den alongside the remainder.
// ----------------------------------------------------------------------------
module pcrc_root (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [pcrc_pkg::NUM_BITS-1:0]  num,
    input  logic [pcrc_pkg::SUM_BITS-1:0]  den,
    output logic                           out_valid,
    output logic [pcrc_pkg::DIST_BITS-1:0] root
);
    import pcrc_pkg::*;

    logic [DIST_BITS-1:0] valid_reg;
    logic [REM_BITS-1:0]  rem_reg [DIST_BITS];
    logic [KD_BITS-1:0]   kd_reg  [DIST_BITS];
    logic [SUM_BITS-1:0]  den_reg [DIST_BITS];
    logic [DIST_BITS-1:0] k_reg   [DIST_BITS];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIST_BITS-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < DIST_BITS; s++)
    begin : g_stage
        localparam int BIT = DIST_BITS - 1 - s;

        logic [REM_BITS-1:0]  rem_in;
        logic [KD_BITS-1:0]   kd_in;
        logic [SUM_BITS-1:0]  den_in;
        logic [DIST_BITS-1:0] k_in;
        logic [REM_BITS-1:0]  trial;
        logic                 take;

        if (s == 0)
        begin : g_first
            assign rem_in = REM_BITS'(num);
            assign kd_in  = '0;
            assign den_in = den;
            assign k_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign kd_in  = kd_reg[s-1];
            assign den_in = den_reg[s-1];
            assign k_in   = k_reg[s-1];
        end

        // Cost of setting this bit: (2k*2^b + 2^2b) * den.
        assign trial = (REM_BITS'(kd_in) << (BIT + 1)) + (REM_BITS'(den_in) << (2 * BIT));
        assign take  = (trial <= rem_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? rem_in - trial : rem_in;
                kd_reg[s]  <= take ? kd_in + (KD_BITS'(den_in) << BIT) : kd_in;
                den_reg[s] <= den_in;
                k_reg[s]   <= k_in | (DIST_BITS'(take) << BIT);
            end
        end
    end

    assign out_valid = valid_reg[DIST_BITS-1];
    assign root      = k_reg[DIST_BITS-1];

endmodule

// File: design/pcb_clearance_rule_check_core.sv
// ----------------------------------------------------------------------------
// Clearance rule check core
// Streams one design-rule check per request beat and returns one response.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats on req_ch carry the action code, two segments (or pads) and
//   a track width; each accepted request yields exactly one response beat on
//   rsp_ch with the severity and the floor of the measured distance.
//   Four segment lanes compute the end-point-to-segment distances in parallel
//   and each feeds a bit-per-stage root pipeline of 25 stages.
//   A request passes through 5 lane stages, 25 root stages, the merge stage
//   and then the response register. One request is taken every cycle while
//   rsp_ch does not stall, since every stage of the lanes and roots accepts a
//   new beat in each cycle that the pipeline is enabled.
//   When rsp_ch stalls, the whole pipeline holds in place and req_ch.ready
//   drops while the held response waits; nothing is dropped or repeated.
//   Thresholds and the board box are written through the APB-style port at
//   byte address 4*index, by the user only while no request is in flight.
//   Reset clears all valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module pcb_clearance_rule_check_core (
    input  logic                               clk,
    input  logic                               rst_n,
    pcrc_req_if.sink                           req_ch,
    pcrc_rsp_if.source                         rsp_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcrc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [pcrc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [pcrc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import pcrc_pkg::*;

    cfg_t                 cfg;
    logic                 en;
    point_t               pt_a, pt_b, pt_c, pt_d, pt_b0;
    point_t               lane_seg_a [NUM_LANES];
    point_t               lane_seg_b [NUM_LANES];
    point_t               lane_pt    [NUM_LANES];
    logic                 lane_valid [NUM_LANES];
    logic [NUM_BITS-1:0]  lane_num   [NUM_LANES];
    logic [SUM_BITS-1:0]  lane_den   [NUM_LANES];
    logic                 root_valid [NUM_LANES];
    logic [DIST_BITS-1:0] root_dist  [NUM_LANES];
    side_t                side_in;
    side_t                side_reg [PIPE_LAT];

    // Merge stage registers.
    logic                 m_valid_reg;
    side_t                m_side_reg;
    logic [DIST_BITS-1:0] m_near_reg;
    logic [DIST_BITS-1:0] m_min_reg;
    logic [DIST_BITS-1:0] min01, min23, min_all;

    // Response registers.
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [DIST_BITS-1:0] warn_limit;

    pcrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pipeline moves whenever the response register can take a beat.
    assign en           = !rsp_valid_reg || rsp_ch.ready;
    assign req_ch.ready = en;

    // Route end points to the lanes; pad-pad collapses lane 0 to a point.
    assign pt_a  = '{x: req_ch.payload.first_start_x,  y: req_ch.payload.first_start_y};
    assign pt_b  = '{x: req_ch.payload.first_end_x,    y: req_ch.payload.first_end_y};
    assign pt_c  = '{x: req_ch.payload.second_start_x, y: req_ch.payload.second_start_y};
    assign pt_d  = '{x: req_ch.payload.second_end_x,   y: req_ch.payload.second_end_y};
    assign pt_b0 = (req_ch.payload.action == ACT_PAD_PAD) ? pt_a : pt_b;

    assign lane_seg_a[0] = pt_a;  assign lane_seg_b[0] = pt_b0; assign lane_pt[0] = pt_c;
    assign lane_seg_a[1] = pt_a;  assign lane_seg_b[1] = pt_b;  assign lane_pt[1] = pt_d;
    assign lane_seg_a[2] = pt_c;  assign lane_seg_b[2] = pt_d;  assign lane_pt[2] = pt_a;
    assign lane_seg_a[3] = pt_c;  assign lane_seg_b[3] = pt_d;  assign lane_pt[3] = pt_b;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        pcrc_seg_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (req_ch.valid),
            .seg_a     (lane_seg_a[i]),
            .seg_b     (lane_seg_b[i]),
            .pt        (lane_pt[i]),
            .out_valid (lane_valid[i]),
            .num       (lane_num[i]),
            .den       (lane_den[i])
        );

        pcrc_root u_root (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (lane_valid[i]),
            .num       (lane_num[i]),
            .den       (lane_den[i]),
            .out_valid (root_valid[i]),
            .root      (root_dist[i])
        );
    end

    // Outline containment and bypass fields, aligned with the lanes.
    always_comb
    begin
        side_in.action      = req_ch.payload.action;
        side_in.track_width = req_ch.payload.track_width;
        side_in.outside     = cfg.outline_enable &&
                              ((req_ch.payload.first_start_x < cfg.board_min_x) ||
                               (req_ch.payload.first_start_x > cfg.board_max_x) ||
                               (req_ch.payload.first_start_y < cfg.board_min_y) ||
                               (req_ch.payload.first_start_y > cfg.board_max_y));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < PIPE_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // Least of the four lane distances.
    always_comb
    begin
        min01   = (root_dist[1] < root_dist[0]) ? root_dist[1] : root_dist[0];
        min23   = (root_dist[3] < root_dist[2]) ? root_dist[3] : root_dist[2];
        min_all = (min23 < min01) ? min23 : min01;
    end

    // Rule decision for the merged item.
    always_comb
    begin
        warn_limit = DIST_BITS'(cfg.clear_floor) + DIST_BITS'(PAD_MARGIN);
        rsp_next   = '0;
        case (m_side_reg.action)
            ACT_WIDTH:
            begin
                rsp_next.measured_distance = DIST_BITS'(m_side_reg.track_width);
                if (m_side_reg.track_width < cfg.width_floor)
                begin
                    rsp_next.severity = SEV_ERROR;
                end
            end
            ACT_TRACK_TRACK:
            begin
                rsp_next.measured_distance = m_min_reg;
                if (m_min_reg < DIST_BITS'(cfg.clear_floor))
                begin
                    rsp_next.severity = SEV_ERROR;
                end
            end
            ACT_TRACK_PAD:
            begin
                rsp_next.measured_distance = m_near_reg;
                if (m_near_reg < warn_limit)
                begin
                    rsp_next.severity = SEV_WARN;
                end
            end
            ACT_PAD_PAD:
            begin
                rsp_next.measured_distance = m_near_reg;
                if (m_near_reg < DIST_BITS'(PAD_OVERLAP_DIST))
                begin
                    rsp_next.severity = SEV_ERROR;
                end
            end
            ACT_PAD_OUTLINE:
            begin
                if (m_side_reg.outside)
                begin
                    rsp_next.severity = SEV_ERROR;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Valid bits of the merge and response stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= root_valid[0];
            rsp_valid_reg <= m_valid_reg;
        end
    end

    // Payload of the merge and response stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= side_reg[PIPE_LAT-1];
            m_near_reg <= root_dist[0];
            m_min_reg  <= min_all;
            rsp_reg    <= rsp_next;
        end
    end

    assign rsp_ch.valid   = rsp_valid_reg;
    assign rsp_ch.payload = rsp_reg;

endmodule

// File: design/pcrc_checker.sv
// ----------------------------------------------------------------------------
// Clearance rule check port checker
// Watches the channels of the core and flags handshake or coding slips.
// ----------------------------------------------------------------------------
`include "pcb_clearance_rule_check_core_defines.svh"

module pcrc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [pcrc_pkg::SEV_BITS-1:0]  rsp_severity,
    input logic [pcrc_pkg::DIST_BITS-1:0] rsp_distance
);
    import pcrc_pkg::*;

    // A stalled response beat stays offered and unchanged.
    `PCRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `PCRC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_severity) && $stable(rsp_distance))

    // Severity never carries a code above the error level.
    `PCRC_ASSERT_SAME(a_sev_code, rsp_valid, rsp_severity <= SEV_ERROR)

    // Requests are taken exactly when the response register can move.
    `PCRC_ASSERT_SAME(a_ready_link, 1'b1, req_ready == (!rsp_valid || rsp_ready))

endmodule

bind pcb_clearance_rule_check_core pcrc_checker u_pcrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req_ch.ready),
    .rsp_valid    (rsp_ch.valid),
    .rsp_ready    (rsp_ch.ready),
    .rsp_severity (rsp_ch.payload.severity),
    .rsp_distance (rsp_ch.payload.measured_distance)
);
